// File: rtl/core/dmc_pkg.sv
`timescale 1ns / 1ps
// dmc_pkg: shared constants, codes and types of the maze carver
// no dependencies

package dmc_pkg;

  localparam int MAX_SIDE_DEF = 32;
  localparam int SIDE_W       = 6;
  localparam int RAND_W       = 32;
  localparam int CELL_W       = 5;
  localparam logic [SIDE_W-1:0] SIDE_RESET = 6'd32;

  // result action codes
  localparam logic [1:0] ACT_CARVE  = 2'd0;
  localparam logic [1:0] ACT_BACK   = 2'd1;
  localparam logic [1:0] ACT_FINISH = 2'd2;

  // neighbor direction codes
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  // request into the remainder unit
  typedef struct packed {
    logic              start;
    logic [RAND_W-1:0] value;
    logic [2:0]        divisor;
  } mod_req_t;

  // answer from the remainder unit
  typedef struct packed {
    logic       done;
    logic [1:0] rem;
  } mod_rsp_t;

endpackage

// File: rtl/core/dmc_ram.sv
`timescale 1ns / 1ps
// dmc_ram: generic single write, single read RAM with registered read
// no dependencies

module dmc_ram #(
  parameter int W     = 1,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/dmc_mod_unit.sv
`timescale 1ns / 1ps
// dmc_mod_unit: radix-4 serial remainder of the random word by a small count
// depends on dmc_pkg

module dmc_mod_unit
  import dmc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  localparam int STEPS = RAND_W / 2;
  localparam int CW    = $clog2(STEPS + 1);

  logic [CW-1:0]     cnt;
  logic              busy;
  logic              done;
  logic [RAND_W-1:0] shreg;
  logic [2:0]        div;
  logic [1:0]        acc;
  logic [3:0]        t;
  logic [3:0]        d1;
  logic [3:0]        d2;
  logic [3:0]        d3;
  logic [1:0]        acc_next;

  // one digit per cycle, remainder kept below the divisor
  always_comb begin
    t  = {acc, shreg[RAND_W-1 -: 2]};
    d1 = {1'b0, div};
    d2 = {div, 1'b0};
    d3 = d1 + d2;
    priority if (t >= d3) begin
      acc_next = 2'(t - d3);
    end else if (t >= d2) begin
      acc_next = 2'(t - d2);
    end else if (t >= d1) begin
      acc_next = 2'(t - d1);
    end else begin
      acc_next = t[1:0];
    end
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CW'(STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      shreg <= req.value;
      div   <= req.divisor;
      acc   <= '0;
    end else if (busy) begin
      shreg <= {shreg[RAND_W-3:0], 2'b00};
      acc   <= acc_next;
    end
  end

  assign rsp = '{done: done, rem: acc};

endmodule

// File: rtl/core/dfs_maze_carver.sv
`timescale 1ns / 1ps
// dfs_maze_carver: randomized depth-first maze carver, one step per random word
// depends on dmc_pkg, dmc_ram, dmc_mod_unit

// After reset the block runs a clearing pass over all
// 2**(2*clog2(MAX_SIDE)) map entries (1024 at the default) with in_stall high.
// A step then takes one item at a time: in_stall stays high from an accepted
// word until its result has been taken. With a non-empty stack a step reads the
// stack top, reads the four neighbors on the single read port of each map,
// evaluates them, writes back a carve (not a backtrack), presents the result and
// returns to idle. It passes through the radix-4 remainder unit when two or more
// neighbors are open, and with an empty stack it first reads and checks cell
// after cell until it finds an unvisited one or runs out. The result is then held
// until taken, and out_stall holds it longer.
module dfs_maze_carver
  import dmc_pkg::*;
#(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SIDE_W-1:0] side_length,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [RAND_W-1:0] random_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        action,
  output logic [CELL_W-1:0] cell_x,
  output logic [CELL_W-1:0] cell_y,
  output logic [1:0]        direction,
  output logic              more_work
);

  localparam int XW    = $clog2(MAX_SIDE);
  localparam int AW    = 2 * XW;
  localparam int DEPTH = 1 << AW;
  localparam int DW    = AW + 1;
  localparam int SW0   = $clog2(MAX_SIDE + 1);
  localparam int EW    = (SW0 > SIDE_W) ? SW0 + 1 : SIDE_W + 1;

  localparam logic [3:0] S_CLR      = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SCAN_RD  = 4'd2;
  localparam logic [3:0] S_SCAN_CHK = 4'd3;
  localparam logic [3:0] S_TOP_RD   = 4'd4;
  localparam logic [3:0] S_TOP_WT   = 4'd5;
  localparam logic [3:0] S_NB       = 4'd6;
  localparam logic [3:0] S_EVAL     = 4'd7;
  localparam logic [3:0] S_MOD      = 4'd8;
  localparam logic [3:0] S_CARVE    = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  logic [3:0]        state;
  logic [SIDE_W-1:0] side_reg;
  logic [DW-1:0]     depth;
  logic [AW-1:0]     clr_cnt;
  logic [XW-1:0]     sx;
  logic [XW-1:0]     sy;
  logic [AW-1:0]     cur;
  logic [2:0]        k;
  logic              pend_ok;
  logic [3:0]        mask;
  logic [1:0]        pick;
  logic [RAND_W-1:0] rnd;

  logic [1:0]        res_action;
  logic [XW-1:0]     res_x;
  logic [XW-1:0]     res_y;
  logic [1:0]        res_dir;
  logic              res_more;

  logic [EW-1:0]     side;
  logic [XW-1:0]     cx;
  logic [XW-1:0]     cy;
  logic [EW-1:0]     cxe;
  logic [EW-1:0]     cye;
  logic [AW-1:0]     adr_n;
  logic [AW-1:0]     adr_e;
  logic [AW-1:0]     adr_s;
  logic [AW-1:0]     adr_w;
  logic [3:0]        inb;
  logic [2:0]        cand_n;
  logic [1:0]        sel_dir;
  logic [1:0]        seen;
  logic [1:0]        prev_dir;
  logic              prev_wall;
  logic [AW-1:0]     nb_adr;

  logic              vis_we;
  logic [AW-1:0]     vis_waddr;
  logic              vis_wdata;
  logic [AW-1:0]     vis_raddr;
  logic              vis_rdata;
  logic              east_we;
  logic [AW-1:0]     east_waddr;
  logic              east_wdata;
  logic [AW-1:0]     east_raddr;
  logic              east_rdata;
  logic              south_we;
  logic [AW-1:0]     south_waddr;
  logic              south_wdata;
  logic [AW-1:0]     south_raddr;
  logic              south_rdata;
  logic              stk_we;
  logic [AW-1:0]     stk_waddr;
  logic [AW-1:0]     stk_wdata;
  logic [AW-1:0]     stk_raddr;
  logic [AW-1:0]     stk_rdata;

  mod_req_t          mreq;
  mod_rsp_t          mrsp;

  // clamp the side to the supported range
  always_comb begin
    side = EW'(side_reg);
    if (side < EW'(2)) begin
      side = EW'(2);
    end else if (side > EW'(MAX_SIDE)) begin
      side = EW'(MAX_SIDE);
    end
  end

  // neighbor addresses and bounds of the top cell
  always_comb begin
    cx    = cur[XW-1:0];
    cy    = cur[AW-1:XW];
    cxe   = EW'(cx);
    cye   = EW'(cy);
    adr_n = {cy - 1'b1, cx};
    adr_e = {cy, cx + 1'b1};
    adr_s = {cy + 1'b1, cx};
    adr_w = {cy, cx - 1'b1};
    inb[DIR_N] = (cy != '0) && (cye - 1'b1 < side) && (cxe < side);
    inb[DIR_E] = (cxe + 1'b1 < side) && (cye < side);
    inb[DIR_S] = (cye + 1'b1 < side) && (cxe < side);
    inb[DIR_W] = (cx != '0) && (cxe - 1'b1 < side) && (cye < side);
  end

  // open neighbor count and the chosen one
  always_comb begin
    cand_n  = 3'(mask[0]) + 3'(mask[1]) + 3'(mask[2]) + 3'(mask[3]);
    sel_dir = DIR_N;
    seen    = '0;
    for (int i = 0; i < 4; i++) begin
      if (mask[i]) begin
        if (seen == pick) begin
          sel_dir = 2'(i);
        end
        seen = seen + 1'b1;
      end
    end
    unique case (sel_dir)
      DIR_N:   nb_adr = adr_n;
      DIR_E:   nb_adr = adr_e;
      DIR_S:   nb_adr = adr_s;
      default: nb_adr = adr_w;
    endcase
  end

  // wall bit of the direction issued last cycle
  always_comb begin
    prev_dir  = 2'(k - 1'b1);
    prev_wall = ((prev_dir == DIR_N) || (prev_dir == DIR_S)) ? south_rdata : east_rdata;
  end

  // memory read addresses
  always_comb begin
    stk_raddr = AW'(depth - 1'b1);
    unique case (k[1:0])
      DIR_N:   vis_raddr = adr_n;
      DIR_E:   vis_raddr = adr_e;
      DIR_S:   vis_raddr = adr_s;
      default: vis_raddr = adr_w;
    endcase
    if (state == S_SCAN_RD) begin
      vis_raddr = {sy, sx};
    end
    south_raddr = (k[1:0] == DIR_N) ? adr_n : cur;
    east_raddr  = (k[1:0] == DIR_W) ? adr_w : cur;
  end

  // memory writes: clearing pass, start push, carve
  always_comb begin
    vis_we      = 1'b0;
    vis_waddr   = nb_adr;
    vis_wdata   = 1'b1;
    east_we     = 1'b0;
    east_waddr  = (sel_dir == DIR_E) ? cur : nb_adr;
    east_wdata  = 1'b0;
    south_we    = 1'b0;
    south_waddr = (sel_dir == DIR_N) ? nb_adr : cur;
    south_wdata = 1'b0;
    stk_we      = 1'b0;
    stk_waddr   = depth[AW-1:0];
    stk_wdata   = nb_adr;
    unique case (state)
      S_CLR: begin
        vis_we      = 1'b1;
        vis_waddr   = clr_cnt;
        vis_wdata   = 1'b0;
        east_we     = 1'b1;
        east_waddr  = clr_cnt;
        east_wdata  = 1'b1;
        south_we    = 1'b1;
        south_waddr = clr_cnt;
        south_wdata = 1'b1;
      end
      S_SCAN_CHK: begin
        if (!vis_rdata) begin
          vis_we    = 1'b1;
          vis_waddr = {sy, sx};
          stk_we    = 1'b1;
          stk_wdata = {sy, sx};
        end
      end
      S_CARVE: begin
        vis_we   = 1'b1;
        stk_we   = 1'b1;
        east_we  = (sel_dir == DIR_E) || (sel_dir == DIR_W);
        south_we = (sel_dir == DIR_N) || (sel_dir == DIR_S);
      end
      default: begin
      end
    endcase
  end

  // remainder request
  always_comb begin
    mreq.start   = (state == S_EVAL) && (cand_n >= 3'd2);
    mreq.value   = rnd;
    mreq.divisor = cand_n;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_cnt  <= '0;
      depth    <= '0;
      side_reg <= SIDE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        side_reg <= side_length;
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            rnd <= random_value;
            sx  <= '0;
            sy  <= '0;
            state <= (depth == '0) ? S_SCAN_RD : S_TOP_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          if (!vis_rdata) begin
            depth <= depth + 1'b1;
            state <= S_TOP_RD;
          end else if (EW'(sx) + 1'b1 < side) begin
            sx    <= sx + 1'b1;
            state <= S_SCAN_RD;
          end else if (EW'(sy) + 1'b1 < side) begin
            sx    <= '0;
            sy    <= sy + 1'b1;
            state <= S_SCAN_RD;
          end else begin
            res_action <= ACT_FINISH;
            res_x      <= '0;
            res_y      <= '0;
            res_dir    <= DIR_N;
            res_more   <= 1'b0;
            state      <= S_OUT;
          end
        end
        S_TOP_RD: begin
          state <= S_TOP_WT;
        end
        S_TOP_WT: begin
          cur   <= stk_rdata;
          k     <= '0;
          mask  <= '0;
          state <= S_NB;
        end
        S_NB: begin
          pend_ok <= inb[k[1:0]];
          if (k != '0) begin
            mask[prev_dir] <= pend_ok && prev_wall && !vis_rdata;
          end
          k <= k + 1'b1;
          if (k == 3'd4) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_x <= cx;
          res_y <= cy;
          pick  <= '0;
          if (cand_n == '0) begin
            depth      <= depth - 1'b1;
            res_action <= ACT_BACK;
            res_dir    <= DIR_N;
            res_more   <= (depth != DW'(1));
            state      <= S_OUT;
          end else if (cand_n == 3'd1) begin
            state <= S_CARVE;
          end else begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          if (mrsp.done) begin
            pick  <= mrsp.rem;
            state <= S_CARVE;
          end
        end
        S_CARVE: begin
          depth      <= depth + 1'b1;
          res_action <= ACT_CARVE;
          res_dir    <= sel_dir;
          res_more   <= 1'b1;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // map and stack memories
  dmc_ram #(.W(1), .DEPTH(DEPTH)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata)
  );

  dmc_ram #(.W(1), .DEPTH(DEPTH)) u_east (
    .clk(clk), .we(east_we), .waddr(east_waddr), .wdata(east_wdata),
    .raddr(east_raddr), .rdata(east_rdata)
  );

  dmc_ram #(.W(1), .DEPTH(DEPTH)) u_south (
    .clk(clk), .we(south_we), .waddr(south_waddr), .wdata(south_wdata),
    .raddr(south_raddr), .rdata(south_rdata)
  );

  dmc_ram #(.W(AW), .DEPTH(DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  // remainder unit
  dmc_mod_unit u_mod (
    .clk(clk), .rst(rst), .req(mreq), .rsp(mrsp)
  );

  // ports
  logic [XW+CELL_W-1:0] res_xw;
  logic [XW+CELL_W-1:0] res_yw;

  assign res_xw    = (XW + CELL_W)'(res_x);
  assign res_yw    = (XW + CELL_W)'(res_y);
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);
  assign action    = res_action;
  assign cell_x    = res_xw[CELL_W-1:0];
  assign cell_y    = res_yw[CELL_W-1:0];
  assign direction = res_dir;
  assign more_work = res_more;

  // a carve always leaves the stack non-empty
  a_carve_more: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == ACT_CARVE) |-> more_work)
    else $error("carve result without more work");

  // a finished step only comes with an empty stack and zero fields
  a_finish_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && action == ACT_FINISH) |->
      (depth == '0 && cell_x == '0 && cell_y == '0 && !more_work))
    else $error("finished result with stack or fields non-zero");

  // the stack never holds more cells than the largest maze
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(MAX_SIDE * MAX_SIDE))
    else $error("stack depth beyond cell count");

  // the remainder is below the count it was taken by
  a_mod_range: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> (3'(mrsp.rem) < cand_n))
    else $error("remainder out of range");

endmodule
